// ===== rtl/pba_pkg.sv =====
package pba_pkg;

	localparam int PBA_NUM_CONTEXTS = 16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [40:0] ALIGN_LOW = 41'd7;

	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_ALLOC  = 3'd1;
	localparam logic [2:0] MODE_RESET  = 3'd2;
	localparam logic [2:0] MODE_REMOVE = 3'd3;
	localparam logic [2:0] MODE_QUERY  = 3'd4;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_ALLOC,
		OP_RESET,
		OP_REMOVE,
		OP_QUERY,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_OVER_CAP  = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] key;
		logic [47:0] base;
		logic [39:0] size;
		logic [39:0] cap;
		logic [39:0] req;
	} pba_item_t;

endpackage

// ===== rtl/pba_front.sv =====
module pba_front import pba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  mode,
	input  logic [63:0] tab_id,
	input  logic [47:0] region_base,
	input  logic [39:0] region_size,
	input  logic [39:0] byte_limit,
	input  logic [39:0] request_bytes,
	output logic        busy,
	output pba_item_t   head,
	output logic        head_valid,
	input  logic        pop
);

	pba_item_t          fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	pba_item_t          item_in;
	op_t                op_in;
	logic               push;

	always_comb begin
		unique case (mode)
			MODE_INIT:   op_in = OP_INIT;
			MODE_ALLOC:  op_in = OP_ALLOC;
			MODE_RESET:  op_in = OP_RESET;
			MODE_REMOVE: op_in = OP_REMOVE;
			MODE_QUERY:  op_in = OP_QUERY;
			default:     op_in = OP_NONE;
		endcase
	end

	always_comb begin
		item_in.op   = op_in;
		item_in.key  = tab_id;
		item_in.base = region_base;
		item_in.size = region_size;
		item_in.cap  = byte_limit;
		item_in.req  = request_bytes;
	end

	assign busy       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (count_q != '0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

// ===== rtl/pba_back.sv =====
module pba_back import pba_pkg::*; #(
	parameter int NUM_CONTEXTS = PBA_NUM_CONTEXTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pba_item_t   head,
	input  logic        head_valid,
	output logic        pop,
	output logic        done,
	output logic [2:0]  status,
	output logic [47:0] address,
	output logic [39:0] used_bytes,
	output logic [39:0] remaining_bytes,
	output logic [40:0] total_bytes
);

	localparam int SLOT_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC
	} state_t;

	state_t              state_q;
	pba_item_t           item_q;
	logic                hit_s1;
	logic                slot_ok_s1;
	logic [SLOT_W-1:0]   slot_s1;

	logic [NUM_CONTEXTS-1:0] valid_q;
	logic [63:0]         key_q   [NUM_CONTEXTS];
	logic [47:0]         mem_base [NUM_CONTEXTS];
	logic [47:0]         mem_cur  [NUM_CONTEXTS];
	logic [48:0]         mem_lim  [NUM_CONTEXTS];
	logic [39:0]         mem_cap  [NUM_CONTEXTS];
	logic [40:0]         mem_tot  [NUM_CONTEXTS];

	logic [47:0]         rd_base_q;
	logic [47:0]         rd_cur_q;
	logic [48:0]         rd_lim_q;
	logic [39:0]         rd_cap_q;
	logic [40:0]         rd_tot_q;

	logic                hit;
	logic                free;
	logic [SLOT_W-1:0]   hit_idx;
	logic [SLOT_W-1:0]   free_idx;

	logic [40:0]         aligned;
	logic [48:0]         end_addr;
	logic [41:0]         cap_sum;
	logic [40:0]         new_total;

	logic                we_init;
	logic                we_cur;
	logic                we_tot;
	logic                set_valid;
	logic                clr_valid;
	logic [47:0]         cur_wdata;
	logic [40:0]         tot_wdata;

	status_t             res_status;
	logic [47:0]         res_addr;
	logic [39:0]         res_used;
	logic [39:0]         res_rem;
	logic [40:0]         res_total;

	logic                done_q;
	status_t             status_q;
	logic [47:0]         address_q;
	logic [39:0]         used_q;
	logic [39:0]         rem_q;
	logic [40:0]         total_q;

	assign pop = head_valid && (state_q == S_IDLE || state_q == S_EXEC);

	// lowest-numbered match and lowest free slot
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = NUM_CONTEXTS - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == item_q.key) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free     = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOOK) begin
			rd_base_q <= mem_base[hit_idx];
			rd_cur_q  <= mem_cur[hit_idx];
			rd_lim_q  <= mem_lim[hit_idx];
			rd_cap_q  <= mem_cap[hit_idx];
			rd_tot_q  <= mem_tot[hit_idx];
		end
	end

	assign aligned   = (41'(item_q.req) + ALIGN_LOW) & ~ALIGN_LOW;
	assign end_addr  = {1'b0, rd_cur_q} + 49'(aligned);
	assign cap_sum   = {1'b0, rd_tot_q} + 42'(item_q.req);
	assign new_total = rd_tot_q + aligned;

	always_comb begin
		we_init    = 1'b0;
		we_cur     = 1'b0;
		we_tot     = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		cur_wdata  = item_q.base;
		tot_wdata  = '0;
		res_status = ST_OK;
		res_addr   = '0;
		res_used   = '0;
		res_rem    = '0;
		res_total  = '0;
		if (state_q == S_EXEC) begin
			unique case (item_q.op)
				OP_INIT: begin
					if (!slot_ok_s1) begin
						res_status = ST_FULL;
					end else begin
						we_init   = 1'b1;
						we_cur    = 1'b1;
						we_tot    = 1'b1;
						set_valid = 1'b1;
					end
				end
				OP_ALLOC: begin
					if (!hit_s1) begin
						res_status = ST_UNKNOWN;
					end else if (cap_sum > {2'b0, rd_cap_q}) begin
						res_status = ST_OVER_CAP;
					end else if (end_addr > rd_lim_q || end_addr[48]) begin
						res_status = ST_EXHAUSTED;
					end else begin
						res_addr  = rd_cur_q;
						we_cur    = 1'b1;
						we_tot    = 1'b1;
						cur_wdata = end_addr[47:0];
						tot_wdata = new_total;
					end
				end
				OP_RESET: begin
					if (!hit_s1) begin
						res_status = ST_UNKNOWN;
					end else begin
						we_cur    = 1'b1;
						cur_wdata = rd_base_q;
					end
				end
				OP_REMOVE: begin
					if (!hit_s1) begin
						res_status = ST_UNKNOWN;
					end else begin
						clr_valid = 1'b1;
					end
				end
				OP_QUERY: begin
					if (!hit_s1) begin
						res_status = ST_UNKNOWN;
					end else begin
						res_used  = 40'(rd_cur_q - rd_base_q);
						res_rem   = (rd_lim_q > {1'b0, rd_cur_q}) ?
							40'(rd_lim_q - {1'b0, rd_cur_q}) : '0;
						res_total = rd_tot_q;
					end
				end
				default: res_status = ST_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we_init) begin
			key_q[slot_s1]    <= item_q.key;
			mem_base[slot_s1] <= item_q.base;
			mem_lim[slot_s1]  <= {1'b0, item_q.base} + 49'(item_q.size);
			mem_cap[slot_s1]  <= item_q.cap;
		end
		if (we_cur) begin
			mem_cur[slot_s1] <= cur_wdata;
		end
		if (we_tot) begin
			mem_tot[slot_s1] <= tot_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (set_valid) begin
			valid_q[slot_s1] <= 1'b1;
		end else if (clr_valid) begin
			valid_q[slot_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			item_q     <= '0;
			hit_s1     <= 1'b0;
			slot_ok_s1 <= 1'b0;
			slot_s1    <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			address_q  <= '0;
			used_q     <= '0;
			rem_q      <= '0;
			total_q    <= '0;
		end else begin
			done_q <= (state_q == S_EXEC);
			if (state_q == S_EXEC) begin
				status_q  <= res_status;
				address_q <= res_addr;
				used_q    <= res_used;
				rem_q     <= res_rem;
				total_q   <= res_total;
			end
			if (pop) begin
				item_q <= head;
			end
			unique case (state_q)
				S_IDLE: state_q <= head_valid ? S_LOOK : S_IDLE;
				S_LOOK: begin
					hit_s1     <= hit;
					slot_ok_s1 <= hit || free;
					slot_s1    <= hit ? hit_idx : free_idx;
					state_q    <= S_EXEC;
				end
				S_EXEC: state_q <= head_valid ? S_LOOK : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign address         = address_q;
	assign used_bytes      = used_q;
	assign remaining_bytes = rem_q;
	assign total_bytes     = total_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_EXEC))
		else $error("result strobe without execute");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK) |=> (state_q == S_EXEC))
		else $error("lookup not followed by execute");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ST_OK) |->
		(address_q == '0 && used_q == '0 && rem_q == '0 && total_q == '0))
		else $error("failed transaction carries data");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && item_q.op == OP_INIT && slot_ok_s1) |=> valid_q[$past(slot_s1)])
		else $error("init did not mark slot valid");

endmodule

// ===== rtl/partitioned_bump_allocator_top.sv =====
// channel   direction  handshake            payload
// command   in         start && !busy       mode, tab_id, region_base, region_size,
//                                           byte_limit, request_bytes
// result    out        done, one cycle      status, address, used_bytes,
//                                           remaining_bytes, total_bytes
//
// A command enters a two-entry queue on the accepting edge; busy is high while it is full.
// The back end runs each transaction as a key lookup, then an execute on the table, and
// pops the next queued command during that execute, so lookups and executes alternate.
// An accepted command passes from the queue through lookup and execute before done rises.
// Reset clears the valid bits and the queue; the table needs no clearing pass.
// Results cannot be stalled: done is high for exactly one cycle per transaction.
module partitioned_bump_allocator_top import pba_pkg::*; #(
	parameter int NUM_CONTEXTS = PBA_NUM_CONTEXTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [63:0] tab_id,
	input  logic [47:0] region_base,
	input  logic [39:0] region_size,
	input  logic [39:0] byte_limit,
	input  logic [39:0] request_bytes,
	output logic        done,
	output logic [2:0]  status,
	output logic [47:0] address,
	output logic [39:0] used_bytes,
	output logic [39:0] remaining_bytes,
	output logic [40:0] total_bytes
);

	pba_item_t head;
	logic      head_valid;
	logic      pop;

	pba_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.mode          (mode),
		.tab_id        (tab_id),
		.region_base   (region_base),
		.region_size   (region_size),
		.byte_limit    (byte_limit),
		.request_bytes (request_bytes),
		.busy          (busy),
		.head          (head),
		.head_valid    (head_valid),
		.pop           (pop)
	);

	pba_back #(
		.NUM_CONTEXTS (NUM_CONTEXTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (head_valid),
		.pop             (pop),
		.done            (done),
		.status          (status),
		.address         (address),
		.used_bytes      (used_bytes),
		.remaining_bytes (remaining_bytes),
		.total_bytes     (total_bytes)
	);

endmodule
